/* design/pgd_pkg.sv */
// Package for the pairwise gravity displacement block.
// Widths of the datapath and the side-band record that rides the pipeline.
// Used by the channel interfaces and by pairwise_gravity_displacement.
`default_nettype none

package pgd_pkg;

  localparam int WordW = 32;            // field width of positions, masses, increments
  localparam int RelW  = WordW + 1;     // signed difference and its magnitude
  localparam int SumW  = RelW + 1;      // |dx| + |dy|
  localparam int SqW   = 2 * RelW;      // dx*dx, dy*dy and their sum
  localparam int HalfW = SqW / 2;       // split point of the squared distance
  localparam int PartW = SumW + HalfW;  // one partial product of the denominator
  localparam int DenW  = 100;           // (|dx|+|dy|) * (dx*dx + dy*dy)
  localparam int ProdW = WordW + RelW;  // mass * |rel|
  localparam int QW    = WordW + 1;     // quotient bits, top bit flags overflow
  localparam int NumW  = ProdW + QW;    // numerator mass*|rel|*2^33
  localparam int CmpW  = DenW + QW - 1; // shifted divisor
  localparam int NL    = 4;             // lanes: first x, first y, second x, second y

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic zero;  // coincident bodies
    logic sx;    // dx negative
    logic sy;    // dy negative
  } side_t;

endpackage

`default_nettype wire

/* design/pgd_in_if.sv */
// Request channel carrying one pair of bodies.
// Depends on pgd_pkg for the word type.
`default_nettype none

interface pgd_in_if;
  import pgd_pkg::*;
  logic  valid;
  logic  ready;
  word_t first_x;
  word_t first_y;
  word_t first_mass;
  word_t second_x;
  word_t second_y;
  word_t second_mass;

  modport source(output valid, first_x, first_y, first_mass, second_x, second_y,
                 second_mass, input ready);
  modport sink(input valid, first_x, first_y, first_mass, second_x, second_y,
               second_mass, output ready);
endinterface

`default_nettype wire

/* design/pgd_out_if.sv */
// Result channel carrying the four displacement increments and the clip flag.
// Depends on pgd_pkg for the word type.
`default_nettype none

interface pgd_out_if;
  import pgd_pkg::*;
  logic  valid;
  logic  ready;
  word_t first_dx;
  word_t first_dy;
  word_t second_dx;
  word_t second_dy;
  logic  saturated;

  modport source(output valid, first_dx, first_dy, second_dx, second_dy, saturated,
                 input ready);
  modport sink(input valid, first_dx, first_dy, second_dx, second_dy, saturated,
               output ready);
endinterface

`default_nettype wire

/* design/pairwise_gravity_displacement.sv */
// Pairwise gravity displacement: pipelined force split and per-body increments.
// Depends on pgd_pkg, pgd_in_if and pgd_out_if.
//
//   channel   direction  payload
//   in_chan   sink       first_x/y/mass, second_x/y/mass
//   out_chan  source     first_dx/dy, second_dx/dy, saturated
//
// One request enters per cycle while the output is not held; each passes 39
// register stages before its result is offered. The depth is set by five
// arithmetic stages, a 33-step restoring divider with one quotient bit per
// stage in each of four lanes, and the output register.
// Reset (rst_n low, synchronous) empties the pipeline.
// A held result freezes all stages together; nothing is dropped or repeated.
`default_nettype none

module pairwise_gravity_displacement import pgd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pgd_in_if.sink    in_chan,
  pgd_out_if.source out_chan
);

  localparam int DivBase = 5;
  localparam int NV      = DivBase + QW + 1;

  logic [NV-1:0] valid_r;
  logic          en;

  assign en           = !valid_r[NV-1] || out_chan.ready;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NV-2:0], in_chan.valid};
    end
  end

  // Stage 0: differences.
  logic [RelW-1:0]  rx_r, ry_r;
  word_t            ma_r, mb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r <= {in_chan.first_x[WordW-1], in_chan.first_x}
            - {in_chan.second_x[WordW-1], in_chan.second_x};
      ry_r <= {in_chan.first_y[WordW-1], in_chan.first_y}
            - {in_chan.second_y[WordW-1], in_chan.second_y};
      ma_r <= in_chan.first_mass;
      mb_r <= in_chan.second_mass;
    end
  end

  // Stage 1: magnitudes, their sum, squares and mass products.
  logic [RelW-1:0]           ax, ay;
  logic [SqW-1:0]            sqx_r, sqy_r;
  logic [SumW-1:0]           sum1_r;
  logic [NL-1:0][ProdW-1:0]  prod1_r;
  side_t                     side1_r;

  assign ax = rx_r[RelW-1] ? (RelW'(0) - rx_r) : rx_r;
  assign ay = ry_r[RelW-1] ? (RelW'(0) - ry_r) : ry_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r      <= SqW'(ax) * SqW'(ax);
      sqy_r      <= SqW'(ay) * SqW'(ay);
      sum1_r     <= SumW'(ax) + SumW'(ay);
      prod1_r[0] <= ProdW'(mb_r) * ProdW'(ax);
      prod1_r[1] <= ProdW'(mb_r) * ProdW'(ay);
      prod1_r[2] <= ProdW'(ma_r) * ProdW'(ax);
      prod1_r[3] <= ProdW'(ma_r) * ProdW'(ay);
      side1_r    <= '{zero: (rx_r == '0) && (ry_r == '0),
                      sx: rx_r[RelW-1], sy: ry_r[RelW-1]};
    end
  end

  // Stage 2: squared distance.
  logic [SqW-1:0]           d2_r;
  logic [SumW-1:0]          sum2_r;
  logic [NL-1:0][ProdW-1:0] prod2_r;
  side_t                    side2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r    <= sqx_r + sqy_r;
      sum2_r  <= sum1_r;
      prod2_r <= prod1_r;
      side2_r <= side1_r;
    end
  end

  // Stage 3: denominator as two partial products.
  logic [PartW-1:0]         lo_r, hi_r;
  logic [NL-1:0][ProdW-1:0] prod3_r;
  side_t                    side3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r    <= PartW'(sum2_r) * PartW'(d2_r[HalfW-1:0]);
      hi_r    <= PartW'(sum2_r) * PartW'(d2_r[SqW-1:HalfW]);
      prod3_r <= prod2_r;
      side3_r <= side2_r;
    end
  end

  // Stage 4 and divider: index j holds the state before quotient bit QW-1-j.
  logic [DenW-1:0]         div_den_r  [0:QW];
  logic [NL-1:0][NumW-1:0] div_rem_r  [0:QW];
  logic [NL-1:0][QW-1:0]   div_q_r    [0:QW];
  side_t                   div_side_r [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      div_den_r[0]  <= DenW'(lo_r) + (DenW'(hi_r) << HalfW);
      for (int l = 0; l < NL; l++) begin
        div_rem_r[0][l] <= {prod3_r[l], {QW{1'b0}}};
      end
      div_q_r[0]    <= '0;
      div_side_r[0] <= side3_r;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    logic [CmpW-1:0] dsh;
    assign dsh = {{(CmpW-DenW){1'b0}}, div_den_r[j]} << K;

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [CmpW-1:0] rem_ext;
      logic            ge;
      assign rem_ext = {{(CmpW-NumW){1'b0}}, div_rem_r[j][l]};
      assign ge      = rem_ext >= dsh;

      always_ff @(posedge clk) begin
        if (en) begin
          div_rem_r[j+1][l] <= ge ? NumW'(rem_ext - dsh) : div_rem_r[j][l];
          div_q_r[j+1][l]   <= div_q_r[j][l] | (QW'(ge) << K);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_den_r[j+1]  <= div_den_r[j];
        div_side_r[j+1] <= div_side_r[j];
      end
    end
  end

  // Output stage: sign, saturation and the coincident-body case.
  logic [NL-1:0]        neg;
  logic [NL-1:0]        lane_sat;
  logic [NL-1:0][WordW-1:0] lane_val;
  logic [NL-1:0][WordW-1:0] res_r;
  logic                 sat_r;
  side_t                fin;

  assign fin = div_side_r[QW];
  // The first body is pushed against dx, the second along it.
  assign neg = {fin.sy, fin.sx, !fin.sy, !fin.sx};

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      lane_sat[l] = 1'b0;
      lane_val[l] = '0;
      if (!fin.zero) begin
        if (neg[l]) begin
          if (div_q_r[QW][l] > QW'(33'h080000000)) begin
            lane_sat[l] = 1'b1;
            lane_val[l] = 32'h80000000;
          end else begin
            lane_val[l] = WordW'(QW'(0) - div_q_r[QW][l]);
          end
        end else begin
          if (div_q_r[QW][l] > QW'(33'h07FFFFFFF)) begin
            lane_sat[l] = 1'b1;
            lane_val[l] = 32'h7FFFFFFF;
          end else begin
            lane_val[l] = div_q_r[QW][l][WordW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= lane_val;
      sat_r <= |lane_sat;
    end
  end

  assign out_chan.valid     = valid_r[NV-1];
  assign out_chan.first_dx  = res_r[0];
  assign out_chan.first_dy  = res_r[1];
  assign out_chan.second_dx = res_r[2];
  assign out_chan.second_dy = res_r[3];
  assign out_chan.saturated = sat_r;

  // A held result freezes the whole valid chain.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!en) && $past(rst_n) |-> $stable(valid_r))
    else $error("valid chain moved during a stall");

  // A zero denominator only arises from coincident bodies.
  a_den_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[DivBase-1] && (div_den_r[0] == '0) |-> div_side_r[0].zero)
    else $error("zero denominator without coincident bodies");

  // Reset leaves the pipeline empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (valid_r == '0))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
